>>> hw/rtl/gbc_pkg.sv
// Package for the genome base counter: shared types, character codes and
// prefix word tables. No dependencies.
package gbc_pkg;

  typedef logic [7:0] byte_t;

  // Result field widths fixed by the block's port contract
  localparam int unsigned BASE_COUNT_W = 48;

  // Character codes
  localparam byte_t CH_NL    = 8'd10;
  localparam byte_t CH_TAB   = 8'd9;
  localparam byte_t CH_SP    = 8'd32;
  localparam byte_t CH_GT    = 8'd62;   // '>'
  localparam byte_t CH_SEMI  = 8'd59;   // ';'
  localparam byte_t CH_SLASH = 8'd47;   // '/'
  localparam byte_t CH_L     = 8'd76;   // 'L'
  localparam byte_t CH_O     = 8'd79;   // 'O'

  // Prefix words, first character at index 0
  localparam int unsigned LOCUS_LEN  = 5;
  localparam int unsigned ORIGIN_LEN = 6;
  localparam int unsigned SLASH_LEN  = 2;
  localparam byte_t WORD_LOCUS  [LOCUS_LEN]  = '{"L", "O", "C", "U", "S"};
  localparam byte_t WORD_ORIGIN [ORIGIN_LEN] = '{"O", "R", "I", "G", "I", "N"};

  // Width of the prefix position; holds the longest word length
  localparam int unsigned PIDX_W = 3;
  typedef logic [PIDX_W-1:0] pidx_t;

  // Letter count width for one byte's contribution (at most six)
  typedef logic [2:0] add_t;

  typedef enum logic [1:0] {
    MODE_UNDECIDED,
    MODE_MATCH,
    MODE_COUNT,
    MODE_SKIP
  } line_mode_t;

  typedef enum logic [1:0] {
    CAND_NONE,
    CAND_LOCUS,
    CAND_ORIGIN,
    CAND_SLASH
  } cand_t;

  // One byte handed from the input register to the parser
  typedef struct packed {
    logic  step;
    byte_t data_byte;
    logic  last_byte;
  } gbc_step_t;

  // One result as formed by the parser
  typedef struct packed {
    logic [BASE_COUNT_W-1:0] base_count;
    logic                    format_found;
    logic                    count_saturated;
  } gbc_result_t;

  function automatic logic is_letter(input byte_t c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic pidx_t prefix_len(input cand_t cand);
    case (cand)
      CAND_LOCUS:  return pidx_t'(LOCUS_LEN);
      CAND_ORIGIN: return pidx_t'(ORIGIN_LEN);
      default:     return pidx_t'(SLASH_LEN);
    endcase
  endfunction

  // Expected character at a prefix position; only used below prefix_len
  function automatic byte_t prefix_char(input cand_t cand, input pidx_t idx);
    byte_t ch;
    ch = CH_SLASH;
    case (cand)
      CAND_LOCUS:  if (idx < pidx_t'(LOCUS_LEN)) ch = WORD_LOCUS[idx];
      CAND_ORIGIN: if (idx < pidx_t'(ORIGIN_LEN)) ch = WORD_ORIGIN[idx];
      default:     ch = CH_SLASH;
    endcase
    return ch;
  endfunction

endpackage

>>> hw/rtl/gbc_if.sv
// Stream interfaces for the genome base counter: byte input channel and
// result channel. Depends on gbc_pkg.
interface gbc_in_if import gbc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gbc_out_if import gbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BASE_COUNT_W-1:0] base_count;
  logic                    format_found;
  logic                    count_saturated;

  modport source (output valid, output base_count, output format_found,
                  output count_saturated, input ready);
  modport sink   (input valid, input base_count, input format_found,
                  input count_saturated, output ready);
endinterface

>>> hw/rtl/genome_base_counter_unit.sv
// Genome base counter, top level: input register, line parser and result
// register. Depends on gbc_pkg, gbc_if and gbc_line_parser.
//
// Takes a FASTA or GenBank text one byte per transfer and, on the byte
// marked last_byte, delivers one result: the saturating count of counted
// letters, whether a format was recognized, and whether the count stuck at
// its maximum. One byte is taken every cycle unless a last byte waits in
// the input register for the output; the parser forms its next state for a
// byte combinationally, with the saturating add of the letter counter as
// the longest path. The last byte passes from the input register through
// the parser into the result register. The input keeps taking bytes while
// a result waits on the output; only a second last byte stalls until that
// result is transferred. After a result the block is ready for a new file.
module genome_base_counter_unit import gbc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  gbc_in_if.sink       in_ch,
  gbc_out_if.source    out_ch
);

  logic        s1_valid_r;
  byte_t       s1_data_r;
  logic        s1_last_r;
  logic        s1_go;
  logic        out_free;
  logic        in_fire;
  gbc_step_t   step;
  gbc_result_t result;
  logic        out_valid_r;
  gbc_result_t out_r;

  // Drain the input register unless a result has nowhere to go
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  assign step.step      = s1_go;
  assign step.data_byte = s1_data_r;
  assign step.last_byte = s1_last_r;

  gbc_line_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.base_count      = out_r.base_count;
  assign out_ch.format_found    = out_r.format_found;
  assign out_ch.count_saturated = out_r.count_saturated;

endmodule

>>> hw/rtl/gbc_line_parser.sv
// Line parser for the genome base counter: per-line and per-file state,
// format detection and the saturating letter count. Depends on gbc_pkg.
module gbc_line_parser import gbc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gbc_step_t   step_i,
  output gbc_result_t result_o
);

  logic                  sb_r,   sb_nxt;
  pidx_t                 pidx_r, pidx_nxt;
  cand_t                 cand_r, cand_nxt;
  line_mode_t            mode_r, mode_nxt;
  pidx_t                 pend_r, pend_nxt;
  logic                  fk_r,   fk_nxt;
  logic                  gb_r,   gb_nxt;
  logic                  org_r,  org_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;

  logic [COUNT_BITS:0]   total_sum;
  logic [COUNT_BITS-1:0] total_sat;
  add_t                  add;

  // Per-byte line state update, then the end-of-file line close
  always_comb begin
    byte_t      c;
    logic       lc;
    logic       letter;
    pidx_t      plen;
    byte_t      pch;
    c        = step_i.data_byte;
    letter   = is_letter(c);
    sb_nxt   = sb_r;
    pidx_nxt = pidx_r;
    cand_nxt = cand_r;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    fk_nxt   = fk_r;
    gb_nxt   = gb_r;
    org_nxt  = org_r;
    add      = '0;
    lc       = gb_r ? org_r : 1'b1;
    plen     = prefix_len(cand_r);
    pch      = prefix_char(cand_r, pidx_r);

    if (c == CH_NL) begin
      // close the line; a broken prefix still counts its letters
      if ((mode_r == MODE_MATCH) && lc) add = add_t'(pend_r);
      sb_nxt   = 1'b1;
      pidx_nxt = '0;
      cand_nxt = CAND_NONE;
      mode_nxt = MODE_UNDECIDED;
      pend_nxt = '0;
    end else if (sb_r) begin
      if ((c != CH_SP) && (c != CH_TAB)) begin
        sb_nxt = 1'b0;
        if (!fk_r && (c == CH_GT)) begin
          fk_nxt   = 1'b1;
          gb_nxt   = 1'b0;
          mode_nxt = MODE_SKIP;
        end else if (!gb_r && ((c == CH_GT) || (c == CH_SEMI))) begin
          mode_nxt = MODE_SKIP;
        end else begin
          if (!fk_r && (c == CH_L))          cand_nxt = CAND_LOCUS;
          else if (gb_r && (c == CH_O))      cand_nxt = CAND_ORIGIN;
          else if (gb_r && (c == CH_SLASH))  cand_nxt = CAND_SLASH;
          else                               cand_nxt = CAND_NONE;

          if (cand_nxt != CAND_NONE) begin
            mode_nxt = MODE_MATCH;
            pidx_nxt = pidx_t'(1);
            pend_nxt = pidx_t'(letter);
          end else if (lc) begin
            mode_nxt = MODE_COUNT;
            add      = add_t'(letter);
          end else begin
            mode_nxt = MODE_SKIP;
          end
        end
      end
    end else if (mode_r == MODE_MATCH) begin
      if ((pidx_r < plen) && (c == pch)) begin
        // advance along the prefix word
        pidx_nxt = pidx_r + pidx_t'(1);
        pend_nxt = pend_r + pidx_t'(letter);
        if (pidx_nxt >= plen) begin
          case (cand_r)
            CAND_LOCUS: begin
              fk_nxt = 1'b1;
              gb_nxt = 1'b1;
            end
            CAND_ORIGIN: org_nxt = 1'b1;
            default:     org_nxt = 1'b0;
          endcase
          mode_nxt = MODE_SKIP;
          cand_nxt = CAND_NONE;
          pend_nxt = '0;
        end
      end else begin
        // prefix broken: the line counts or is skipped from here on
        if (lc) begin
          add      = add_t'(pend_r) + add_t'(letter);
          mode_nxt = MODE_COUNT;
        end else begin
          mode_nxt = MODE_SKIP;
        end
        cand_nxt = CAND_NONE;
        pend_nxt = '0;
      end
    end else if (mode_r == MODE_COUNT) begin
      add = add_t'(letter);
    end

    // final byte closes an unterminated line
    if (step_i.last_byte && (mode_nxt == MODE_MATCH) && (gb_nxt ? org_nxt : 1'b1)) begin
      add = add + add_t'(pend_nxt);
    end
  end

  // Saturating count update
  assign total_sum = {1'b0, total_r} + (COUNT_BITS+1)'(add);
  assign total_sat = total_sum[COUNT_BITS] ? '1 : total_sum[COUNT_BITS-1:0];
  assign total_nxt = total_sat;

  // Form the result from the state after this byte
  always_comb begin
    logic [BASE_COUNT_W+COUNT_BITS-1:0] wide;
    wide = {{BASE_COUNT_W{1'b0}}, total_sat};
    result_o.format_found    = fk_nxt;
    result_o.base_count      = fk_nxt ? wide[BASE_COUNT_W-1:0] : '0;
    result_o.count_saturated = fk_nxt && (total_sat == '1);
  end

  // Hold state; return to the start-of-file state after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step_i.step && step_i.last_byte)) begin
      sb_r    <= 1'b1;
      pidx_r  <= '0;
      cand_r  <= CAND_NONE;
      mode_r  <= MODE_UNDECIDED;
      pend_r  <= '0;
      fk_r    <= 1'b0;
      gb_r    <= 1'b0;
      org_r   <= 1'b0;
      total_r <= '0;
    end else if (step_i.step) begin
      sb_r    <= sb_nxt;
      pidx_r  <= pidx_nxt;
      cand_r  <= cand_nxt;
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      fk_r    <= fk_nxt;
      gb_r    <= gb_nxt;
      org_r   <= org_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

>>> hw/rtl/gbc_checker.sv
// Port-level checks for the genome base counter, bound to the top level.
// Depends on gbc_pkg and genome_base_counter_unit.
module gbc_checker import gbc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [BASE_COUNT_W-1:0] out_base_count,
  input logic                    out_format_found,
  input logic                    out_count_saturated
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_base_count)
      && $stable(out_format_found) && $stable(out_count_saturated))
    else $error("result changed while stalled");

  // Unknown format reports an empty count
  a_no_format: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_format_found |-> out_base_count == '0 && !out_count_saturated)
    else $error("count given without a recognized format");

  // Saturation only with a recognized format and a nonzero count
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count_saturated |-> out_format_found && out_base_count != '0)
    else $error("saturation flag inconsistent");

  // Empty output side never blocks input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output empty");

  // Reset clears the result
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind genome_base_counter_unit gbc_checker u_gbc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_base_count      (out_ch.base_count),
  .out_format_found    (out_ch.format_found),
  .out_count_saturated (out_ch.count_saturated)
);

>>> sim/testbench.sv
// Testbench for genome_base_counter_unit: sends FASTA, GenBank and noise
// texts one byte per transfer and checks every result against a predictor
// or a scripted value. Depends on gbc_pkg, gbc_if and the RTL of the block.
module testbench import gbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_BITS = 48;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int unsigned RANDOM_BYTES = 1580;

  typedef enum int unsigned {
    LN_SEQ, LN_HEADER, LN_COMMENT, LN_LOCUS, LN_ORIGIN, LN_CLOSE, LN_NOISE, LN_BLANK
  } line_kind_t;

  typedef enum int unsigned { DOC_FASTA, DOC_GENBANK, DOC_NOISE } doc_kind_t;

  typedef struct {
    string       text;
    byte_t       tail;
    bit          typed;
    gbc_result_t want;
  } case_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gbc_in_if  in_ch ();
  gbc_out_if out_ch ();

  genome_base_counter_unit #(.COUNT_BITS(COUNT_BITS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser copy kept by the testbench
  logic                  blank_run;
  int unsigned           word_pos;
  cand_t                 word_cand;
  line_mode_t            mode;
  int unsigned           held;
  logic                  fmt_known;
  logic                  gb_mode;
  logic                  in_origin;
  logic [COUNT_BITS-1:0] letter_sum;

  gbc_result_t tallies_due [$];
  byte_t       doc [$];
  bit          hurry;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned found_count;

  function automatic bit is_alpha(input byte_t c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic string word_of(input cand_t k);
    case (k)
      CAND_LOCUS:  return "LOCUS";
      CAND_ORIGIN: return "ORIGIN";
      default:     return "//";
    endcase
  endfunction

  function automatic bit line_counts();
    return gb_mode ? in_origin : 1'b1;
  endfunction

  // Saturating add into the letter total
  function automatic void add_bases(input int unsigned n);
    logic [COUNT_BITS-1:0] step;
    step = COUNT_BITS'(n);
    if (letter_sum > COUNT_MAX - step) letter_sum = COUNT_MAX;
    else letter_sum = letter_sum + step;
  endfunction

  function automatic void new_line();
    blank_run = 1'b1;
    word_pos  = 0;
    word_cand = CAND_NONE;
    mode      = MODE_UNDECIDED;
    held      = 0;
  endfunction

  function automatic void reset_parser();
    new_line();
    fmt_known  = 1'b0;
    gb_mode    = 1'b0;
    in_origin  = 1'b0;
    letter_sum = '0;
  endfunction

  // Broken prefix: the letters matched so far count if the line counts
  function automatic void abandon_word(input byte_t c);
    if (line_counts()) begin
      add_bases(held + (is_alpha(c) ? 1 : 0));
      mode = MODE_COUNT;
    end else begin
      mode = MODE_SKIP;
    end
    word_cand = CAND_NONE;
    held      = 0;
  endfunction

  function automatic void match_word(input byte_t c);
    string w;
    w = word_of(word_cand);
    if (word_pos < w.len() && c == byte_t'(w[word_pos])) begin
      word_pos++;
      if (is_alpha(c)) held++;
      if (word_pos >= w.len()) begin
        case (word_cand)
          CAND_LOCUS: begin
            fmt_known = 1'b1;
            gb_mode   = 1'b1;
          end
          CAND_ORIGIN: in_origin = 1'b1;
          default:     in_origin = 1'b0;
        endcase
        mode      = MODE_SKIP;
        word_cand = CAND_NONE;
        held      = 0;
      end
    end else begin
      abandon_word(c);
    end
  endfunction

  // First non-blank byte of a line decides how the line is handled
  function automatic void open_line(input byte_t c);
    blank_run = 1'b0;
    if (!fmt_known && c == CH_GT) begin
      fmt_known = 1'b1;
      gb_mode   = 1'b0;
      mode      = MODE_SKIP;
      return;
    end
    if (!gb_mode && (c == CH_GT || c == CH_SEMI)) begin
      mode = MODE_SKIP;
      return;
    end
    word_cand = CAND_NONE;
    if (!fmt_known && c == CH_L) word_cand = CAND_LOCUS;
    else if (gb_mode && c == CH_O) word_cand = CAND_ORIGIN;
    else if (gb_mode && c == CH_SLASH) word_cand = CAND_SLASH;
    if (word_cand != CAND_NONE) begin
      mode     = MODE_MATCH;
      word_pos = 1;
      held     = is_alpha(c) ? 1 : 0;
    end else if (line_counts()) begin
      mode = MODE_COUNT;
      if (is_alpha(c)) add_bases(1);
    end else begin
      mode = MODE_SKIP;
    end
  endfunction

  function automatic void close_line();
    if (mode == MODE_MATCH) abandon_word(CH_NL);
    new_line();
  endfunction

  // Advance the parser copy by one byte; returns 1 when a result is due
  function automatic bit tally_byte(input byte_t c, input logic last,
                                    output gbc_result_t r);
    r = '0;
    if (c == CH_NL) close_line();
    else if (blank_run) begin
      if (c != CH_SP && c != CH_TAB) open_line(c);
    end else if (mode == MODE_MATCH) match_word(c);
    else if (mode == MODE_COUNT && is_alpha(c)) add_bases(1);
    if (!last) return 1'b0;
    close_line();
    if (fmt_known) begin
      r.base_count      = letter_sum[BASE_COUNT_W-1:0];
      r.format_found    = 1'b1;
      r.count_saturated = (letter_sum == COUNT_MAX);
    end
    reset_parser();
    return 1'b1;
  endfunction

  // Text generation
  function automatic byte_t pick_char(input bit wild);
    string       bases;
    int unsigned roll;
    int unsigned b;
    bases = "ACGTNacgtn";
    roll  = wild ? 99 : $urandom_range(0, 99);
    if (roll < 70) return byte_t'(bases[$urandom_range(0, 9)]);
    if (roll < 82) return byte_t'(($urandom_range(0, 1) ? 65 : 97) + $urandom_range(0, 25));
    if (roll < 94) return byte_t'($urandom_range(32, 126));
    b = $urandom_range(0, 254);
    if (b >= 10) b++;
    return byte_t'(b);
  endfunction

  function automatic void put_chars(input int unsigned n, input bit wild);
    repeat (n) doc.push_back(pick_char(wild));
  endfunction

  function automatic void put_blanks();
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) doc.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endfunction

  // Full or cut prefix word, sometimes corrupted, then a random tail
  function automatic void put_word(input string w);
    int unsigned n;
    put_blanks();
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w.len()) : w.len();
    for (int i = 0; i < n; i++) doc.push_back(byte_t'(w[i]));
    if ($urandom_range(0, 7) == 0) doc.push_back(byte_t'($urandom_range(32, 126)));
    put_chars($urandom_range(0, 6), $urandom_range(0, 3) == 0);
    doc.push_back(CH_NL);
  endfunction

  function automatic void put_line(input line_kind_t kind);
    case (kind)
      LN_SEQ: begin
        put_blanks();
        put_chars($urandom_range(0, 10), 1'b0);
        doc.push_back(CH_NL);
      end
      LN_HEADER: begin
        put_blanks();
        doc.push_back(CH_GT);
        put_chars($urandom_range(0, 8), 1'b0);
        doc.push_back(CH_NL);
      end
      LN_COMMENT: begin
        put_blanks();
        doc.push_back(CH_SEMI);
        put_chars($urandom_range(0, 8), 1'b0);
        doc.push_back(CH_NL);
      end
      LN_LOCUS:  put_word("LOCUS");
      LN_ORIGIN: put_word("ORIGIN");
      LN_CLOSE:  put_word("//");
      LN_NOISE: begin
        put_chars($urandom_range(0, 12), 1'b1);
        doc.push_back(CH_NL);
      end
      default: begin
        put_blanks();
        doc.push_back(CH_NL);
      end
    endcase
  endfunction

  function automatic line_kind_t body_kind();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 13) return LN_SEQ;
    return line_kind_t'($urandom_range(LN_HEADER, LN_BLANK));
  endfunction

  function automatic void build_doc(input doc_kind_t kind);
    doc.delete();
    case (kind)
      DOC_FASTA: begin
        if ($urandom_range(0, 2) == 0) put_line($urandom_range(0, 1) ? LN_COMMENT : LN_BLANK);
        repeat ($urandom_range(1, 2)) begin
          put_line(LN_HEADER);
          repeat ($urandom_range(1, 3)) put_line(body_kind());
        end
      end
      DOC_GENBANK: begin
        if ($urandom_range(0, 3) == 0) put_line(LN_SEQ);
        put_line(LN_LOCUS);
        repeat ($urandom_range(0, 2)) put_line(body_kind());
        put_line(LN_ORIGIN);
        repeat ($urandom_range(1, 3)) put_line(body_kind());
        put_line(LN_CLOSE);
        if ($urandom_range(0, 3) == 0) put_line(body_kind());
      end
      default: begin
        repeat ($urandom_range(1, 4)) put_line(line_kind_t'($urandom_range(LN_SEQ, LN_BLANK)));
      end
    endcase
    // Leave the final line open half of the time
    if (doc.size() > 1 && doc[doc.size()-1] == CH_NL && $urandom_range(0, 1) == 1)
      void'(doc.pop_back());
    if (doc.size() == 0) doc.push_back(pick_char(1'b1));
  endfunction

  // Drive one byte and hold it until the transfer
  task automatic send_byte(input byte_t b, input logic last, input bit typed = 1'b0,
                           input gbc_result_t want = '0);
    int unsigned gap;
    gbc_result_t got;
    gap = hurry ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
    if (tally_byte(b, last, got)) begin
      tallies_due.push_back(typed ? want : got);
      files_sent++;
      if (got.format_found) found_count++;
    end
  endtask

  // Hold the input until every expected result has been transferred
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tallies_due.size() != 0);
  endtask

  task automatic flag_field(input string field, input logic [BASE_COUNT_W-1:0] want,
                            input logic [BASE_COUNT_W-1:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Result side: random stalls, compare each transfer with the oldest expectation
  initial begin : result_side
    int unsigned stall;
    gbc_result_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (out_ch.valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      if (tallies_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got count %0d found %b sat %b",
                 $time, out_ch.base_count, out_ch.format_found, out_ch.count_saturated);
        mismatches++;
      end else begin
        want = tallies_due.pop_front();
        if (out_ch.base_count !== want.base_count)
          flag_field("base_count", want.base_count, out_ch.base_count);
        if (out_ch.format_found !== want.format_found)
          flag_field("format_found", BASE_COUNT_W'(want.format_found),
                     BASE_COUNT_W'(out_ch.format_found));
        if (out_ch.count_saturated !== want.count_saturated)
          flag_field("count_saturated", BASE_COUNT_W'(want.count_saturated),
                     BASE_COUNT_W'(out_ch.count_saturated));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    case_row_t   script [4];
    int unsigned start_bytes;
    doc_kind_t   kind;

    mismatches  = 0;
    bytes_sent  = 0;
    files_sent  = 0;
    found_count = 0;
    hurry       = 1'b0;
    reset_parser();

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Lone zero byte with no format; FASTA with header, blank skip, open last line
    script[0] = '{"", 8'h00, 1'b1, '{48'd0, 1'b0, 1'b0}};
    script[1] = '{">x\n\tAc", 8'hFF, 1'b1, '{48'd2, 1'b1, 1'b0}};
    // GenBank: broken ORIGIN prefix inside the section, text after the closing word
    script[2] = '{"LOCUS\nORIGIN\nOa\n//", "g", 1'b0, '0};
    // Comment line, broken LOCUS before any format, format fixed on the last byte
    script[3] = '{";Q\nLOx\n", ">", 1'b0, '0};

    foreach (script[r]) begin
      for (int i = 0; i < script[r].text.len(); i++)
        send_byte(byte_t'(script[r].text[i]), 1'b0);
      send_byte(script[r].tail, 1'b1, script[r].typed, script[r].want);
    end
    drain_results();

    // Random files, mostly well formed
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      kind = ($urandom_range(0, 9) < 4) ? DOC_FASTA :
             ($urandom_range(0, 5) < 4) ? DOC_GENBANK : DOC_NOISE;
      build_doc(kind);
      if ($urandom_range(0, 9) == 0) drain_results();
      hurry = ($urandom_range(0, 3) == 0);
      foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tallies_due.size() != 0);
    repeat (20) @(posedge clk);

    $display("summary: %0d bytes in %0d files, %0d with a recognized format, %0d without",
             bytes_sent, files_sent, found_count, files_sent - found_count);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
